[sv/crgf_pkg.sv]
// crgf_pkg: shared types and constants for the carved row gap fill renderer
// no dependencies
package crgf_pkg;

  localparam int unsigned MAX_GAP = 62;
  localparam logic [14:0] HUE_FULL = 15'd23040;
  localparam logic [14:0] HUE_HALF = 15'd11520;
  localparam logic [14:0] HUE_QUARTER = 15'd5760;

  localparam logic [0:0] CFG_FILL_GAPS = 1'b0;
  localparam logic [0:0] CFG_FILL_MODE = 1'b1;

  localparam logic [1:0] MODE_COPY = 2'd0;
  localparam logic [1:0] MODE_AVG = 2'd1;
  localparam logic [1:0] MODE_RAMP = 2'd2;

  typedef struct packed {
    logic [14:0] hue;
    logic [15:0] sat;
    logic [15:0] lum;
    logic [15:0] alpha;
    logic [5:0]  gap_after;
    logic        last_in_row;
  } in_item_t;

  typedef struct packed {
    logic [14:0] out_hue;
    logic [15:0] out_sat;
    logic [15:0] out_lum;
    logic [15:0] out_alpha;
    logic        is_fill;
    logic        run_last;
    logic        row_end;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HELD,
    ST_FILL_MUL,
    ST_FILL_DIV,
    ST_FILL_EMIT,
    ST_LAST
  } state_t;

endpackage

[sv/carved_row_gap_fill_renderer_unit.sv]
// carved_row_gap_fill_renderer_unit: top level of the gap fill renderer
// depends on crgf_pkg
//
// usage: surviving nodes of a carved row enter on the in_ channel in row
// order, each with the count of removed pixels after it. one node is held;
// when the next arrives the held pixel goes out, then its gap's fill pixels
// (copy, average, or linear gradient per fill_mode), and the node arriving
// is held, or sent at once as the row end when last_in_row is set.
// out_ carries one pixel per item; run_last marks the final pixel caused
// by an input item, row_end the final pixel of the row.
// timing: one item at a time. the held pixel is loaded at the accepting
// edge and shows on out_ the next cycle. copy and average fills go out
// from the emit state alone. a gradient fill pixel takes four passes
// through the shared 16x6 multiplier and the shared restoring divider,
// one pass per channel, then the emit state. a row end node that follows
// a held node goes out from its own ST_LAST state. in_ready is high
// only in the idle/held states with the output register free.
// a stalled receiver holds out_valid and the result, and the sequencer
// waits at its next output load. reset clears the held node and sets
// fill_gaps=1, fill_mode=copy; no clearing pass is needed.
module carved_row_gap_fill_renderer_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  crgf_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output crgf_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [1:0]           cfg_wdata
);
  import crgf_pkg::*;

  state_t state_r, state_nxt;
  logic fill_gaps_r;
  logic [1:0] fill_mode_r;

  // held (left) node and arriving (right) node
  logic [14:0] lh_r, rh_r;
  logic [15:0] ls_r, ll_r, la_r, rs_r, rl_r, ra_r;
  logic [5:0] gap_r, rgap_r, n_r, k_r;
  logic rlast_r;

  // per channel gradient context: ch_r picks the channel in flight
  logic [1:0] ch_r;
  logic [6:0] rem_r;
  logic [15:0] sh_r;   // dividend bits shifting out, quotient bits in
  logic [3:0] bit_r;
  logic [14:0] gh_r;
  logic [15:0] gs_r, gl_r, ga_r;

  out_item_t obuf_r, obuf_nxt;
  logic ovalid_r;
  logic load;
  logic obuf_free;
  assign obuf_free = !ovalid_r || out_ready;
  assign out_valid = ovalid_r;
  assign out_data = obuf_r;

  // incoming hue folded into range
  logic [14:0] in_hue;
  assign in_hue = (in_data.hue >= HUE_FULL) ? in_data.hue - HUE_FULL : in_data.hue;

  // fill count for the held node's gap
  logic [5:0] n_new;
  assign n_new = !fill_gaps_r ? 6'd0 :
                 ((gap_r > 6'(MAX_GAP)) ? 6'(MAX_GAP) : gap_r);

  // hue distance terms
  logic [14:0] hd, hc;
  assign hd = (lh_r > rh_r) ? lh_r - rh_r : rh_r - lh_r;
  assign hc = (hd > HUE_HALF) ? HUE_FULL - hd : hd;
  logic hup;
  assign hup = (hc == HUE_HALF) ? 1'b0 : ((hd < HUE_HALF) ? (lh_r <= rh_r) : (lh_r > rh_r));

  // average hue
  logic [15:0] hsum;
  logic [14:0] havg;
  logic [15:0] hwr;
  always_comb begin
    hsum = {1'b0, lh_r} + {1'b0, rh_r};
    hwr = 16'(({1'b0, hsum} + 17'd23040) >> 1);
    if (hd == HUE_HALF) begin
      havg = ((lh_r < rh_r) ? lh_r : rh_r) + HUE_QUARTER;
      if (havg >= HUE_HALF) havg = havg - HUE_HALF;
    end else if (hd > HUE_HALF) begin
      havg = (hwr >= {1'b0, HUE_FULL}) ? 15'(hwr - {1'b0, HUE_FULL}) : hwr[14:0];
    end else begin
      havg = hsum[15:1];
    end
  end

  // average of the other channels, carry kept
  logic [15:0] savg, lavg, aavg;
  assign savg = 16'((17'(ls_r) + 17'(rs_r)) >> 1);
  assign lavg = 16'((17'(ll_r) + 17'(rl_r)) >> 1);
  assign aavg = 16'((17'(la_r) + 17'(ra_r)) >> 1);

  // channel select for the shared multiplier
  logic [15:0] dl, dr, dabs;
  always_comb begin
    case (ch_r)
      2'd0: begin dl = {1'b0, lh_r}; dr = {1'b0, rh_r}; end
      2'd1: begin dl = ls_r; dr = rs_r; end
      2'd2: begin dl = ll_r; dr = rl_r; end
      default: begin dl = la_r; dr = ra_r; end
    endcase
    if (ch_r == 2'd0) dabs = {1'b0, hc};
    else dabs = (dl <= dr) ? dr - dl : dl - dr;
  end

  // |diff| * k is below den * 2^16, so the top six bits seed the remainder
  logic [21:0] prod;
  assign prod = 22'(dabs) * 22'(k_r);

  logic [6:0] den;
  assign den = {1'b0, n_r} + 7'd1;
  logic [7:0] trial;
  assign trial = {rem_r, sh_r[15]} - {1'b0, den};
  logic [15:0] qfin;
  assign qfin = {sh_r[14:0], ~trial[7]};

  // apply the step to the channel
  logic [15:0] rampv;
  logic [15:0] hsumup, hsumdn;
  logic [14:0] hfin;
  always_comb begin
    rampv = (dl <= dr) ? dl + qfin : dl - qfin;
    hsumup = {1'b0, lh_r} + qfin;
    hsumdn = {1'b0, lh_r} + {1'b0, HUE_FULL} - qfin;
    if (hup)
      hfin = (hsumup >= {1'b0, HUE_FULL}) ? 15'(hsumup - {1'b0, HUE_FULL}) : hsumup[14:0];
    else
      hfin = (hsumdn >= {1'b0, HUE_FULL}) ? 15'(hsumdn - {1'b0, HUE_FULL}) : hsumdn[14:0];
  end

  // this fill pixel closes the run unless a row end node follows
  logic fill_last;
  assign fill_last = (k_r == n_r) && !rlast_r;

  always_comb begin
    state_nxt = state_r;
    in_ready = 1'b0;
    load = 1'b0;
    obuf_nxt = obuf_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = obuf_free;
        if (in_valid && obuf_free) begin
          if (in_data.last_in_row) begin
            // row of one node goes straight out
            load = 1'b1;
            obuf_nxt = '{in_hue, in_data.sat, in_data.lum, in_data.alpha,
                         1'b0, 1'b1, 1'b1};
          end else begin
            state_nxt = ST_HELD;
          end
        end
      end
      ST_HELD: begin
        in_ready = obuf_free;
        if (in_valid && obuf_free) begin
          load = 1'b1;
          obuf_nxt = '{lh_r, ls_r, ll_r, la_r, 1'b0,
                       (n_new == 6'd0) && !in_data.last_in_row, 1'b0};
          if (n_new != 6'd0)
            state_nxt = (fill_mode_r == MODE_RAMP) ? ST_FILL_MUL : ST_FILL_EMIT;
          else if (in_data.last_in_row)
            state_nxt = ST_LAST;
        end
      end
      ST_FILL_MUL: state_nxt = ST_FILL_DIV;
      ST_FILL_DIV: begin
        if (bit_r == 4'd15)
          state_nxt = (ch_r == 2'd3) ? ST_FILL_EMIT : ST_FILL_MUL;
      end
      ST_FILL_EMIT: begin
        if (obuf_free) begin
          load = 1'b1;
          if (fill_mode_r == MODE_AVG)
            obuf_nxt = '{havg, savg, lavg, aavg, 1'b1, fill_last, 1'b0};
          else if (fill_mode_r == MODE_RAMP)
            obuf_nxt = '{gh_r, gs_r, gl_r, ga_r, 1'b1, fill_last, 1'b0};
          else
            obuf_nxt = '{lh_r, ls_r, ll_r, la_r, 1'b1, fill_last, 1'b0};
          if (k_r == n_r)
            state_nxt = rlast_r ? ST_LAST : ST_HELD;
          else if (fill_mode_r == MODE_RAMP)
            state_nxt = ST_FILL_MUL;
        end
      end
      ST_LAST: begin
        // the arriving node ends the row
        if (obuf_free) begin
          load = 1'b1;
          obuf_nxt = '{rh_r, rs_r, rl_r, ra_r, 1'b0, 1'b1, 1'b1};
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_gaps_r <= 1'b1;
      fill_mode_r <= MODE_COPY;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_FILL_GAPS) fill_gaps_r <= cfg_wdata[0];
        else fill_mode_r <= cfg_wdata;
      end
      if (load) ovalid_r <= 1'b1;
      else if (out_ready) ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) obuf_r <= obuf_nxt;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready && !in_data.last_in_row) begin
          lh_r <= in_hue; ls_r <= in_data.sat; ll_r <= in_data.lum;
          la_r <= in_data.alpha; gap_r <= in_data.gap_after;
        end
      end
      ST_HELD: begin
        if (in_valid && in_ready) begin
          rh_r <= in_hue; rs_r <= in_data.sat; rl_r <= in_data.lum;
          ra_r <= in_data.alpha; rgap_r <= in_data.gap_after;
          rlast_r <= in_data.last_in_row;
          n_r <= n_new;
          k_r <= 6'd1;
          ch_r <= 2'd0;
          if (n_new == 6'd0 && !in_data.last_in_row) begin
            lh_r <= in_hue; ls_r <= in_data.sat; ll_r <= in_data.lum;
            la_r <= in_data.alpha; gap_r <= in_data.gap_after;
          end
        end
      end
      ST_FILL_MUL: begin
        rem_r <= {1'b0, prod[21:16]};
        sh_r <= prod[15:0];
        bit_r <= 4'd0;
      end
      ST_FILL_DIV: begin
        // restoring divide, one quotient bit per cycle
        if (!trial[7]) rem_r <= trial[6:0];
        else rem_r <= {rem_r[5:0], sh_r[15]};
        sh_r <= qfin;
        bit_r <= bit_r + 4'd1;
        if (bit_r == 4'd15) begin
          ch_r <= ch_r + 2'd1;
          case (ch_r)
            2'd0: gh_r <= hfin;
            2'd1: gs_r <= rampv;
            2'd2: gl_r <= rampv;
            default: ga_r <= rampv;
          endcase
        end
      end
      ST_FILL_EMIT: begin
        if (obuf_free) begin
          k_r <= k_r + 6'd1;
          // gap done and the row goes on: the arriving node becomes the held one
          if (fill_last) begin
            lh_r <= rh_r; ls_r <= rs_r; ll_r <= rl_r; la_r <= ra_r;
            gap_r <= rgap_r;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

[sv/crgf_checker.sv]
// crgf_checker: port level checks on the gap fill renderer
// depends on crgf_pkg; bound to carved_row_gap_fill_renderer_unit
module crgf_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input crgf_pkg::out_item_t out_data
);
  import crgf_pkg::*;

  // a stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled item changed");

  // row end always closes a run
  a_rowend: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.row_end |-> out_data.run_last)
    else $error("row end without run last");

  // a fill pixel never carries the row end flag
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_fill |-> !out_data.row_end)
    else $error("fill pixel ends row");

  // an input item is only taken while the output register can load
  a_in_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !out_valid || out_ready)
    else $error("input item taken while output stalled");

endmodule

bind carved_row_gap_fill_renderer_unit crgf_checker u_crgf_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

[tb/tb_carved_row_gap_fill_renderer_unit.sv]
// testbench for carved_row_gap_fill_renderer_unit: drives carved rows of hsla nodes,
// predicts the emitted pixels and compares them field by field
// depends on crgf_pkg and the renderer rtl
module tb_carved_row_gap_fill_renderer_unit;
  import crgf_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [1:0] cfg_wdata = 2'd0;

  carved_row_gap_fill_renderer_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor copy of the register file and held node
  logic        pr_fill_gaps;
  logic [1:0]  pr_fill_mode;
  logic [14:0] hold_hue;
  logic [15:0] hold_sat, hold_lum, hold_alpha;
  logic [5:0]  hold_gap;
  logic        hold_valid;

  out_item_t pixel_q[$];
  int errors = 0;
  int idle_cycles = 0;

  // long receiver hold-off, counted here, requested by the stimulus
  bit hold_off_req = 1'b0;
  int hold_off_left = 0;

  // channel ramp: move from l toward r by |r-l|*k/den
  function automatic logic [15:0] chan_ramp(logic [15:0] l, logic [15:0] r, int k, int den);
    int unsigned lv, rv;
    lv = l;
    rv = r;
    if (lv <= rv) return 16'(lv + ((rv - lv) * k) / den);
    return 16'(lv - ((lv - rv) * k) / den);
  endfunction

  // average on the shorter arc, diametric pair takes the smaller average
  function automatic logic [14:0] hue_mid(logic [14:0] l, logic [14:0] r);
    int unsigned lv, rv, d, lo;
    lv = l;
    rv = r;
    d = (lv > rv) ? lv - rv : rv - lv;
    lo = (lv < rv) ? lv : rv;
    if (d == HUE_HALF) return 15'((lo + HUE_QUARTER) % HUE_HALF);
    if (d > HUE_HALF) return 15'(((lv + rv + HUE_FULL) / 2) % HUE_FULL);
    return 15'((lv + rv) / 2);
  endfunction

  // gradient along the shorter arc, diametric pair steps downward
  function automatic logic [14:0] hue_grad(logic [14:0] l, logic [14:0] r, int k, int den);
    int unsigned lv, rv, d, c, stp;
    bit up;
    lv = l;
    rv = r;
    d = (lv > rv) ? lv - rv : rv - lv;
    c = (d > HUE_HALF) ? HUE_FULL - d : d;
    stp = (c * k) / den;
    if (c == HUE_HALF) up = 1'b0;
    else if (d < HUE_HALF) up = (lv <= rv);
    else up = (lv > rv);
    if (up) return 15'((lv + stp) % HUE_FULL);
    return 15'((lv + HUE_FULL - stp) % HUE_FULL);
  endfunction

  function automatic out_item_t mk_pixel(logic [14:0] h, logic [15:0] s, logic [15:0] l,
                                         logic [15:0] a, logic fill, logic rend);
    out_item_t p;
    p.out_hue = h;
    p.out_sat = s;
    p.out_lum = l;
    p.out_alpha = a;
    p.is_fill = fill;
    p.run_last = 1'b0;
    p.row_end = rend;
    return p;
  endfunction

  // works out the pixels one accepted node causes and queues them
  task automatic render_node(in_item_t it);
    logic [14:0] h;
    int n, cnt;
    out_item_t p;
    h = (it.hue >= HUE_FULL) ? 15'(it.hue - HUE_FULL) : it.hue;
    cnt = 0;
    if (hold_valid) begin
      pixel_q.push_back(mk_pixel(hold_hue, hold_sat, hold_lum, hold_alpha, 1'b0, 1'b0));
      cnt++;
      if (pr_fill_gaps) begin
        n = (hold_gap > MAX_GAP) ? MAX_GAP : hold_gap;
        for (int k = 1; k <= n; k++) begin
          if (pr_fill_mode == MODE_AVG)
            p = mk_pixel(hue_mid(hold_hue, h), 16'((17'(hold_sat) + 17'(it.sat)) >> 1),
                         16'((17'(hold_lum) + 17'(it.lum)) >> 1),
                         16'((17'(hold_alpha) + 17'(it.alpha)) >> 1), 1'b1, 1'b0);
          else if (pr_fill_mode == MODE_RAMP)
            p = mk_pixel(hue_grad(hold_hue, h, k, n + 1),
                         chan_ramp(hold_sat, it.sat, k, n + 1),
                         chan_ramp(hold_lum, it.lum, k, n + 1),
                         chan_ramp(hold_alpha, it.alpha, k, n + 1), 1'b1, 1'b0);
          else
            p = mk_pixel(hold_hue, hold_sat, hold_lum, hold_alpha, 1'b1, 1'b0);
          pixel_q.push_back(p);
          cnt++;
        end
      end
    end
    if (it.last_in_row) begin
      pixel_q.push_back(mk_pixel(h, it.sat, it.lum, it.alpha, 1'b0, 1'b1));
      cnt++;
      hold_valid = 1'b0;
    end else begin
      hold_hue = h;
      hold_sat = it.sat;
      hold_lum = it.lum;
      hold_alpha = it.alpha;
      hold_gap = it.gap_after;
      hold_valid = 1'b1;
    end
    if (cnt > 0) pixel_q[$].run_last = 1'b1;
  endtask

  // result side: stall pattern plus the long hold-off, and checking
  int stall_phase = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pixel_q.size() == 0) begin
          $error("unexpected pixel %p", out_data);
          errors++;
        end else begin
          out_item_t e;
          e = pixel_q.pop_front();
          if (out_data.out_hue !== e.out_hue)
            $error("out_hue exp %0d got %0d", e.out_hue, out_data.out_hue);
          if (out_data.out_sat !== e.out_sat)
            $error("out_sat exp %0d got %0d", e.out_sat, out_data.out_sat);
          if (out_data.out_lum !== e.out_lum)
            $error("out_lum exp %0d got %0d", e.out_lum, out_data.out_lum);
          if (out_data.out_alpha !== e.out_alpha)
            $error("out_alpha exp %0d got %0d", e.out_alpha, out_data.out_alpha);
          if (out_data.is_fill !== e.is_fill)
            $error("is_fill exp %0d got %0d", e.is_fill, out_data.is_fill);
          if (out_data.run_last !== e.run_last)
            $error("run_last exp %0d got %0d", e.run_last, out_data.run_last);
          if (out_data.row_end !== e.row_end)
            $error("row_end exp %0d got %0d", e.row_end, out_data.row_end);
          if (out_data !== e) errors++;
        end
      end
      // ready pattern: quiet stretches, stretches of light and heavy stall
      stall_phase <= stall_phase + 1;
      if (hold_off_req && hold_off_left == 0) begin
        hold_off_left <= 300;
        out_ready <= 1'b0;
      end else if (hold_off_left > 0) begin
        hold_off_left <= hold_off_left - 1;
        out_ready <= (hold_off_left == 1);
      end else if ((stall_phase / 200) % 3 == 0) out_ready <= 1'b1;
      else if ((stall_phase / 200) % 3 == 1) out_ready <= ($urandom_range(3) != 0);
      else out_ready <= ($urandom_range(2) == 0);
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FILL_GAPS) pr_fill_gaps = val[0];
    else pr_fill_mode = val;
  endtask

  // waits until every pixel is back, then lets the sequencer settle
  task automatic drain;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // offers one node, holds it until accepted, leaves valid high
  task automatic send_node(in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    // ready is settled mid cycle, so the next edge accepts when it is high
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    render_node(it);
  endtask

  task automatic gap_cycles(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic in_item_t rand_node(bit last, int max_gap);
    in_item_t it;
    it.hue = ($urandom_range(15) == 0) ? 15'($urandom_range(32767, 23040))
                                      : 15'($urandom_range(23039));
    case ($urandom_range(7))
      0: it.hue = 15'd0;
      1: it.hue = 15'd11520;
      default: ;
    endcase
    it.sat = 16'($urandom);
    it.lum = 16'($urandom);
    it.alpha = 16'($urandom);
    it.gap_after = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(max_gap));
    it.last_in_row = last;
    return it;
  endfunction

  // directed table: node fields and, for rows of one, the pixel read off at a glance
  typedef struct {
    in_item_t node;
    bit       has_exp;
    out_item_t pix;
  } dir_row_t;

  dir_row_t dir_tab[$];

  function automatic dir_row_t drow(logic [14:0] h, logic [15:0] s, logic [15:0] l,
                                    logic [15:0] a, logic [5:0] g, logic last,
                                    bit has_exp, logic [14:0] eh);
    dir_row_t r;
    r.node = '{h, s, l, a, g, last};
    r.has_exp = has_exp;
    r.pix = '{eh, s, l, a, 1'b0, 1'b1, 1'b1};
    return r;
  endfunction

  int mode_sel[4] = '{0, 1, 2, 3};

  initial begin
    in_item_t it;
    int row_len, burst;
    pr_fill_gaps = 1'b1;
    pr_fill_mode = MODE_COPY;
    hold_valid = 1'b0;
    hold_hue = '0; hold_sat = '0; hold_lum = '0; hold_alpha = '0; hold_gap = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // rows of one node after reset, extremes, hue out of range
    dir_tab.push_back(drow(15'd0, 16'd0, 16'd0, 16'd0, 6'd63, 1'b1, 1'b1, 15'd0));
    dir_tab.push_back(drow(15'd23039, 16'hffff, 16'hffff, 16'hffff, 6'd0, 1'b1, 1'b1,
                           15'd23039));
    dir_tab.push_back(drow(15'd32767, 16'h1234, 16'h8000, 16'h0001, 6'd5, 1'b1, 1'b1,
                           15'd9727));
    dir_tab.push_back(drow(15'd23040, 16'h5555, 16'haaaa, 16'h00ff, 6'd0, 1'b1, 1'b1, 15'd0));
    // copy fill with a gap above the limit, a diametric pair, then the row end
    dir_tab.push_back(drow(15'd100, 16'd10, 16'd20, 16'd30, 6'd63, 1'b0, 1'b0, 15'd0));
    dir_tab.push_back(drow(15'd11620, 16'd50, 16'd60, 16'd70, 6'd3, 1'b0, 1'b0, 15'd0));
    dir_tab.push_back(drow(15'd23000, 16'hffff, 16'd0, 16'h8000, 6'd2, 1'b1, 1'b0, 15'd0));
    foreach (dir_tab[i]) begin
      send_node(dir_tab[i].node);
      if (dir_tab[i].has_exp && pixel_q[$] !== dir_tab[i].pix) begin
        $error("directed row %0d predictor mismatch", i);
        errors++;
      end
    end
    in_valid <= 1'b0;
    drain();

    // every fill mode on the same shaped rows, then filling off
    foreach (mode_sel[m]) begin
      write_reg(CFG_FILL_MODE, 2'(mode_sel[m]));
      send_node('{15'd0, 16'd0, 16'hffff, 16'd0, 6'd4, 1'b0});
      send_node('{15'd11520, 16'hffff, 16'd0, 16'hffff, 6'd62, 1'b0});
      send_node('{15'd22000, 16'd100, 16'd200, 16'd300, 6'd1, 1'b0});
      send_node('{15'd500, 16'd300, 16'd200, 16'd100, 6'd0, 1'b1});
      in_valid <= 1'b0;
      drain();
    end
    write_reg(CFG_FILL_GAPS, 2'd0);
    send_node('{15'd1000, 16'd1, 16'd2, 16'd3, 6'd9, 1'b0});
    send_node('{15'd2000, 16'd4, 16'd5, 16'd6, 6'd9, 1'b1});
    in_valid <= 1'b0;
    drain();

    // random phases, each writing fill_gaps and fill_mode first
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_FILL_GAPS, ((ph % 4) != 3) ? 2'd1 : 2'd0);
      write_reg(CFG_FILL_MODE, 2'(ph % 4));
      for (int r = 0; r < 10; r++) begin
        row_len = ($urandom_range(7) == 0) ? 1 : $urandom_range(6, 2);
        if (ph == 2 && r == 3) hold_off_req = 1'b1;
        for (int j = 0; j < row_len; j++) begin
          // mostly short gaps, a few long ones, ramp kept shorter since it is slow
          it = rand_node(j == row_len - 1, (pr_fill_mode == MODE_RAMP) ? 6 : 12);
          send_node(it);
          hold_off_req = 1'b0;
          burst = $urandom_range(4);
          if (burst == 0) gap_cycles($urandom_range(12, 1));
        end
        if ($urandom_range(3) == 0) gap_cycles($urandom_range(30));
      end
      in_valid <= 1'b0;
      // sender waits for every pixel before the next setting
      drain();
    end

    drain();
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
